// ===== hdl/trapezoidal_profile_evaluator_top_macros.svh =====
// assertion helpers shared by the profile evaluator modules
// the body refers to the clk and rst_n of the module that uses it
`ifndef TRAPEZOIDAL_PROFILE_EVALUATOR_TOP_MACROS_SVH
`define TRAPEZOIDAL_PROFILE_EVALUATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TPE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TPE_ASSERT_SAME(label, ante, cons, msg)
`define TPE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/tpe_pkg.sv =====
package tpe_pkg;

  localparam int POS_W      = 32;
  localparam int TIME_W     = 32;
  localparam int PHASE_W    = 3;
  localparam int CFG_ADDR_W = 4;
  localparam int OP_W       = 64;
  localparam int MUL_W      = 96;
  localparam int NUM_W      = 105;
  localparam int DEN_W      = 72;
  localparam int QB         = 35;
  localparam int QE_W       = QB + 1;
  localparam int CMP_W      = DEN_W + QB;
  localparam int DIV_STAGES = QB + 1;

  // 0.0001 in q8.24
  localparam logic [POS_W-1:0] TINY_LIMIT = 32'd1678;
  localparam logic [TIME_W-1:0] DUR_RESET = 32'd65536;

  typedef enum logic [PHASE_W-1:0] {
    PH_BEFORE = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REG_START_POS     = 2'd0,
    REG_END_POS       = 2'd1,
    REG_MOVE_DURATION = 2'd2,
    REG_START_TIME    = 2'd3
  } reg_idx_t;

  // register values plus terms derived from them
  typedef struct packed {
    logic signed [POS_W-1:0] start_pos;
    logic signed [POS_W-1:0] end_pos;
    logic [TIME_W-1:0]       dur;
    logic [TIME_W-1:0]       t0;
    logic [POS_W-1:0]        mag;
    logic                    neg;
    logic [34:0]             dur7;
    logic [35:0]             dur13;
    logic [DEN_W-1:0]        den91;
    logic [DEN_W-1:0]        den26;
    logic [DEN_W-1:0]        den13;
  } cfg_view_t;

  // classified request handed from front to back
  typedef struct packed {
    phase_t                  phase;
    logic                    special;
    logic                    neg;
    logic signed [POS_W-1:0] base;
    logic [POS_W-1:0]        mag;
    logic                    pos_sq;
    logic [OP_W-1:0]         pos_op;
    logic [OP_W-1:0]         vel_op;
  } item_t;

endpackage

// ===== hdl/tpe_ifs.sv =====
interface tpe_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now;

  modport source (output valid, output now, input ready);
  modport sink (input valid, input now, output ready);
endinterface

interface tpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] acceleration;
  logic [2:0]         phase;

  modport source (output valid, output position, output velocity, output acceleration,
                  output phase, input ready);
  modport sink (input valid, input position, input velocity, input acceleration,
                input phase, output ready);
endinterface

// ===== hdl/tpe_cfg.sv =====
module tpe_cfg import tpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_view_t             view
);

  logic [31:0] start_r, end_r, dur_r, t0_r;
  logic [POS_W-1:0] mag_r;
  logic neg_r;
  logic [63:0] tt_r;
  logic [34:0] dur7_r;
  logic [35:0] dur13_r;
  logic [DEN_W-1:0] den91_r;
  logic signed [32:0] dd;
  logic wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      dur_r   <= DUR_RESET;
      t0_r    <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_START_POS:     start_r <= pwdata;
        REG_END_POS:       end_r   <= pwdata;
        REG_MOVE_DURATION: dur_r   <= pwdata;
        REG_START_TIME:    t0_r    <= pwdata;
        default:           t0_r    <= t0_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_POS:     prdata = start_r;
      REG_END_POS:       prdata = end_r;
      REG_MOVE_DURATION: prdata = dur_r;
      REG_START_TIME:    prdata = t0_r;
      default:           prdata = '0;
    endcase
  end

  // derived terms are registered after a write
  assign dd = $signed({end_r[31], end_r}) - $signed({start_r[31], start_r});

  always_ff @(posedge clk) begin
    neg_r   <= dd[32];
    mag_r   <= dd[32] ? 32'(-dd) : dd[31:0];
    tt_r    <= 64'(dur_r) * 64'(dur_r);
    dur7_r  <= 35'(dur_r) * 35'd7;
    dur13_r <= 36'(dur_r) * 36'd13;
    den91_r <= DEN_W'(tt_r) * DEN_W'(91);
  end

  always_comb begin
    view.start_pos = $signed(start_r);
    view.end_pos   = $signed(end_r);
    view.dur       = dur_r;
    view.t0        = t0_r;
    view.mag       = mag_r;
    view.neg       = neg_r;
    view.dur7      = dur7_r;
    view.dur13     = dur13_r;
    view.den91     = den91_r;
    view.den13     = DEN_W'(dur13_r);
    view.den26     = DEN_W'(dur13_r) << 1;
  end

endmodule

// ===== hdl/tpe_front.sv =====
`include "trapezoidal_profile_evaluator_top_macros.svh"

module tpe_front import tpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_view_t view,
  tpe_in_if.sink    in_if,
  input  logic      full,
  output logic      push,
  output item_t     push_item
);

  logic f1_v_r, f2_v_r;
  logic [TIME_W-1:0] el_r;
  item_t item_r, item_nxt;
  logic f_adv;

  logic [30:0] u;
  logic [36:0] u20;
  logic [37:0] cv;
  logic [TIME_W-1:0] w;
  logic tiny, over, in_acc, in_cru;

  assign f_adv       = !f2_v_r || !full;
  assign push        = f2_v_r && !full;
  assign push_item   = item_r;
  assign in_if.ready = f_adv || !f1_v_r;

  // elapsed time, wrapping difference read signed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (f_adv || !f1_v_r) f1_v_r <= in_if.valid;
      if (f_adv) f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_adv || !f1_v_r) el_r <= in_if.now - view.t0;
    if (f_adv) item_r <= item_nxt;
  end

  assign u      = el_r[30:0];
  assign u20    = 37'(u) * 37'd20;
  assign tiny   = view.mag < TINY_LIMIT;
  assign over   = (view.dur == '0) || ({1'b0, u} > view.dur);
  assign in_acc = u20 <= 37'(view.dur7);
  assign in_cru = u20 <= 37'(view.dur13);
  assign w      = view.dur - {1'b0, u};
  assign cv     = 38'(u) * 38'd40 - 38'(view.dur7);

  always_comb begin
    item_nxt.phase   = PH_DONE;
    item_nxt.special = 1'b1;
    item_nxt.neg     = view.neg;
    item_nxt.base    = view.start_pos;
    item_nxt.mag     = view.mag;
    item_nxt.pos_sq  = 1'b0;
    item_nxt.pos_op  = 64'(u);
    item_nxt.vel_op  = 64'(u) << 16;
    if (tiny) begin
      item_nxt.phase = PH_DONE;
    end else if (el_r[31]) begin
      item_nxt.phase = PH_BEFORE;
    end else if (over) begin
      item_nxt.base = view.end_pos;
    end else if (in_acc) begin
      item_nxt.phase   = PH_ACCEL;
      item_nxt.special = 1'b0;
      item_nxt.pos_sq  = 1'b1;
    end else if (in_cru) begin
      item_nxt.phase   = PH_CRUISE;
      item_nxt.special = 1'b0;
      item_nxt.pos_op  = 64'(cv);
      item_nxt.vel_op  = 64'd65536;
    end else begin
      // decelerate, measured back from the end of the move
      item_nxt.phase   = PH_DECEL;
      item_nxt.special = 1'b0;
      item_nxt.base    = view.end_pos;
      item_nxt.pos_sq  = 1'b1;
      item_nxt.pos_op  = 64'(w);
      item_nxt.vel_op  = 64'(w) << 16;
    end
  end

  `TPE_ASSERT_NEXT(a_front_hold, f2_v_r && full, f2_v_r && (item_r == $past(item_r)), "front request lost while queue full")

endmodule

// ===== hdl/tpe_queue.sv =====
`include "trapezoidal_profile_evaluator_top_macros.svh"

module tpe_queue import tpe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] count_r;

  assign full  = count_r == CNT_W'(DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop) rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

  `TPE_ASSERT_SAME(a_q_push_full, push, !full, "push into full queue")
  `TPE_ASSERT_NEXT(a_q_grow, push && !pop, count_r == $past(count_r) + 1'b1, "queue count did not grow")

endmodule

// ===== hdl/tpe_div.sv =====
module tpe_div import tpe_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic             sel,
  input  logic [DEN_W-1:0] den_a,
  input  logic [DEN_W-1:0] den_b,
  output logic [QE_W-1:0]  quo
);

  logic [NUM_W-1:0] rem_r [DIV_STAGES];
  logic [QB-1:0]    q_r   [DIV_STAGES];
  logic             sel_r [DIV_STAGES];
  logic             ovf_r [DIV_STAGES];

  logic [DEN_W-1:0] den0;
  logic [CMP_W-1:0] sh0;

  // first stage only flags a quotient too large for the result bits
  assign den0 = sel ? den_b : den_a;
  assign sh0  = CMP_W'(den0) << QB;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      q_r[0]   <= '0;
      sel_r[0] <= sel;
      ovf_r[0] <= CMP_W'(num) >= sh0;
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stage
    localparam int B = QB - j;
    logic [DEN_W-1:0] den_j;
    logic [CMP_W-1:0] sh_j;
    logic take_j;

    assign den_j  = sel_r[j-1] ? den_b : den_a;
    assign sh_j   = CMP_W'(den_j) << B;
    assign take_j = CMP_W'(rem_r[j-1]) >= sh_j;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take_j ? rem_r[j-1] - sh_j[NUM_W-1:0] : rem_r[j-1];
        q_r[j]   <= q_r[j-1] | (take_j ? (QB'(1) << B) : QB'(0));
        sel_r[j] <= sel_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  assign quo = ovf_r[DIV_STAGES-1] ? (QE_W'(1) << QB) : QE_W'(q_r[DIV_STAGES-1]);

endmodule

// ===== hdl/tpe_back.sv =====
`include "trapezoidal_profile_evaluator_top_macros.svh"

module tpe_back import tpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_view_t view,
  input  logic      empty,
  input  item_t     head,
  output logic      pop,
  tpe_out_if.source out_if
);

  typedef enum logic [1:0] {K_ONE, K_20, K_200, K_400} kcode_t;

  typedef struct packed {
    phase_t                  phase;
    logic                    special;
    logic                    neg;
    logic signed [POS_W-1:0] base;
  } side_t;

  function automatic logic [NUM_W-1:0] kmul(input logic [MUL_W-1:0] m, input kcode_t k);
    logic [NUM_W-1:0] x;
    x = NUM_W'(m);
    case (k)
      K_ONE:   kmul = x;
      K_20:    kmul = (x << 4) + (x << 2);
      K_200:   kmul = (x << 7) + (x << 6) + (x << 3);
      K_400:   kmul = (x << 8) + (x << 7) + (x << 4);
      default: kmul = x;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    if (v > 39'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -39'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  logic b_adv;

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  side_t s1_side_r, s2_side_r, s3_side_r, s4_side_r;
  logic [POS_W-1:0] s1_mag_r, s2_mag_r;
  logic [OP_W-1:0] s1_ppos_r, s1_pvel_r;
  logic [63:0] s2_plo_r, s2_phi_r, s2_vlo_r, s2_vhi_r;
  logic [MUL_W-1:0] s3_mpos_r, s3_mvel_r, s3_macc_r;
  logic [NUM_W-1:0] s4_npos_r, s4_nvel_r, s4_nacc_r;
  logic s3_cru, s4_cru;

  logic  ln_v_r    [DIV_STAGES];
  side_t ln_side_r [DIV_STAGES];

  logic [QE_W-1:0] q_pos, q_vel, q_acc;
  side_t last;
  logic signed [37:0] sp, sv, sa;
  logic signed [38:0] base39, pos_w, vel_w, acc_w;

  logic out_v_r;
  logic signed [31:0] out_pos_r, out_vel_r, out_acc_r;
  phase_t out_phase_r;

  assign b_adv = !out_v_r || out_if.ready;
  assign pop   = b_adv && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) ln_v_r[i] <= 1'b0;
    end else if (b_adv) begin
      s1_v_r    <= !empty;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      ln_v_r[0] <= s4_v_r;
      for (int i = 1; i < DIV_STAGES; i++) ln_v_r[i] <= ln_v_r[i-1];
      out_v_r   <= ln_v_r[DIV_STAGES-1];
    end
  end

  assign s3_cru = s3_side_r.phase == PH_CRUISE;
  assign s4_cru = s4_side_r.phase == PH_CRUISE;

  // numerator pipeline: square, times magnitude in halves, sum, constant scale
  always_ff @(posedge clk) begin
    if (b_adv) begin
      s1_side_r <= '{phase: head.phase, special: head.special, neg: head.neg,
                     base: head.base};
      s1_mag_r  <= head.mag;
      s1_ppos_r <= head.pos_sq ? 64'(head.pos_op[31:0]) * 64'(head.pos_op[31:0])
                               : head.pos_op;
      s1_pvel_r <= head.vel_op;

      s2_side_r <= s1_side_r;
      s2_mag_r  <= s1_mag_r;
      s2_plo_r  <= 64'(s1_ppos_r[31:0]) * 64'(s1_mag_r);
      s2_phi_r  <= 64'(s1_ppos_r[63:32]) * 64'(s1_mag_r);
      s2_vlo_r  <= 64'(s1_pvel_r[31:0]) * 64'(s1_mag_r);
      s2_vhi_r  <= 64'(s1_pvel_r[63:32]) * 64'(s1_mag_r);

      s3_side_r <= s2_side_r;
      s3_mpos_r <= MUL_W'(s2_plo_r) + (MUL_W'(s2_phi_r) << 32);
      s3_mvel_r <= MUL_W'(s2_vlo_r) + (MUL_W'(s2_vhi_r) << 32);
      s3_macc_r <= MUL_W'(s2_mag_r) << 32;

      s4_side_r <= s3_side_r;
      s4_npos_r <= kmul(s3_mpos_r, s3_cru ? K_ONE : K_200);
      s4_nvel_r <= kmul(s3_mvel_r, s3_cru ? K_20 : K_400);
      s4_nacc_r <= kmul(s3_macc_r, K_400);

      ln_side_r[0] <= s4_side_r;
      for (int i = 1; i < DIV_STAGES; i++) ln_side_r[i] <= ln_side_r[i-1];
    end
  end

  tpe_div u_div_pos (
    .clk(clk), .en(b_adv), .num(s4_npos_r), .sel(s4_cru),
    .den_a(view.den91), .den_b(view.den26), .quo(q_pos)
  );

  tpe_div u_div_vel (
    .clk(clk), .en(b_adv), .num(s4_nvel_r), .sel(s4_cru),
    .den_a(view.den91), .den_b(view.den13), .quo(q_vel)
  );

  tpe_div u_div_acc (
    .clk(clk), .en(b_adv), .num(s4_nacc_r), .sel(1'b0),
    .den_a(view.den91), .den_b(view.den91), .quo(q_acc)
  );

  // sign, offset from the base position and clamp
  always_comb begin
    last   = ln_side_r[DIV_STAGES-1];
    sp     = last.neg ? -$signed(38'(q_pos)) : $signed(38'(q_pos));
    sv     = last.neg ? -$signed(38'(q_vel)) : $signed(38'(q_vel));
    sa     = last.neg ? -$signed(38'(q_acc)) : $signed(38'(q_acc));
    base39 = 39'($signed(last.base));
    if (last.special) pos_w = base39;
    else if (last.phase == PH_DECEL) pos_w = base39 - 39'(sp);
    else pos_w = base39 + 39'(sp);
    vel_w = last.special ? '0 : 39'(sv);
    if (last.phase == PH_ACCEL && !last.special) acc_w = 39'(sa);
    else if (last.phase == PH_DECEL && !last.special) acc_w = -39'(sa);
    else acc_w = '0;
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_pos_r   <= sat32(pos_w);
      out_vel_r   <= sat32(vel_w);
      out_acc_r   <= sat32(acc_w);
      out_phase_r <= last.phase;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.position     = out_pos_r;
  assign out_if.velocity     = out_vel_r;
  assign out_if.acceleration = out_acc_r;
  assign out_if.phase        = out_phase_r;

  `TPE_ASSERT_SAME(a_b_rest_zero, out_v_r && (out_phase_r == PH_BEFORE || out_phase_r == PH_DONE), out_vel_r == '0 && out_acc_r == '0, "motion reported at rest")

endmodule

// ===== hdl/trapezoidal_profile_evaluator_top.sv =====
// trapezoidal profile evaluator: takes one sample time per cycle while the queue
// has room and returns the position, velocity, acceleration and phase of the
// configured move at that time, fully pipelined. a sample passes a two stage front
// (elapsed time, then phase classification), a small queue, and a back end of four
// multiply stages and three parallel long dividers of 36 stages each (one quotient
// bit per stage after the first). throughput is one result per cycle while the
// result side keeps taking them. the user must write configuration through the
// apb-style port only while no request is in flight; the block does not enforce
// this. derived terms (scaled duration, its square) are registered after a write.
module trapezoidal_profile_evaluator_top import tpe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tpe_in_if.sink                in_if,
  tpe_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_view_t view;
  logic push, full, pop, empty;
  item_t push_item, head;

  // register file and derived move constants
  tpe_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .view(view)
  );

  // accept and classify
  tpe_front u_front (
    .clk(clk), .rst_n(rst_n), .view(view), .in_if(in_if),
    .full(full), .push(push), .push_item(push_item)
  );

  // decouples front stalls from back stalls
  tpe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  // arithmetic and output register
  tpe_back u_back (
    .clk(clk), .rst_n(rst_n), .view(view), .empty(empty), .head(head),
    .pop(pop), .out_if(out_if)
  );

endmodule

// ===== verif/trapezoidal_profile_evaluator_top_test.sv =====
`timescale 1ns / 100ps

module trapezoidal_profile_evaluator_top_test;
  import tpe_pkg::*;

  typedef struct {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    phase_t             phase;
  } sample_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tpe_in_if  in_bus();
  tpe_out_if out_bus();

  trapezoidal_profile_evaluator_top dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_bus.sink), .out_if(out_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the move registers
  logic [31:0] cur_start = 32'd0;
  logic [31:0] cur_end   = 32'd0;
  logic [31:0] cur_dur   = DUR_RESET;
  logic [31:0] cur_t0    = 32'd0;

  logic [31:0] pending_now[$];   // sample times waiting to be sent
  sample_t     profile_q[$];     // predicted samples waiting for their result
  int          mismatches = 0;
  bit          no_idle = 0;      // stretches with no gaps on either side
  int          send_gap = 0;
  int          take_stall = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // floor(f1*f2*f3 / (g1*g2)) capped
  function automatic longint unsigned scaled_ratio(longint unsigned f1, longint unsigned f2,
      longint unsigned f3, longint unsigned g1, longint unsigned g2, longint unsigned cap);
    bit [191:0] num;
    bit [191:0] den;
    bit [191:0] quo;
    num = 192'(f1) * 192'(f2) * 192'(f3);
    den = 192'(g1) * 192'(g2);
    quo = num / den;
    if (quo > 192'(cap)) return cap;
    return quo[63:0];
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // expected sample of the configured move at time now_t
  function automatic sample_t profile_at(logic [31:0] now_t);
    longint qs;
    longint qe;
    longint dd;
    bit ng;
    longint unsigned mg;
    longint unsigned dur;
    longint unsigned u;
    longint unsigned w;
    longint el;
    longint pos;
    longint vel;
    longint acc;
    longint unsigned acc_mag;
    phase_t ph;
    sample_t r;
    qs = longint'(signed'(cur_start));
    qe = longint'(signed'(cur_end));
    dd = qe - qs;
    ng = dd < 0;
    mg = ng ? -dd : dd;
    dur = cur_dur;
    el = longint'(signed'(now_t - cur_t0));
    vel = 0;
    acc = 0;
    if (mg < TINY_LIMIT) begin
      pos = qs; ph = PH_DONE;
    end else if (el < 0) begin
      pos = qs; ph = PH_BEFORE;
    end else if (dur == 0 || el > longint'(dur)) begin
      pos = qe; ph = PH_DONE;
    end else begin
      u = el;
      acc_mag = scaled_ratio(mg * 400, 64'd1 << 32, 1, 91 * dur, dur, 64'd1 << 31);
      if (20 * u <= 7 * dur) begin
        ph = PH_ACCEL;
        pos = qs + (ng ? -1 : 1) *
              longint'(scaled_ratio(mg * 200, u, u, 91 * dur, dur, 64'd1 << 34));
        vel = (ng ? -1 : 1) *
              longint'(scaled_ratio(mg * 400, u, 65536, 91 * dur, dur, 64'd1 << 31));
        acc = ng ? -longint'(acc_mag) : longint'(acc_mag);
      end else if (20 * u <= 13 * dur) begin
        ph = PH_CRUISE;
        pos = qs + (ng ? -1 : 1) *
              longint'(scaled_ratio(mg, 40 * u - 7 * dur, 1, 26, dur, 64'd1 << 34));
        vel = (ng ? -1 : 1) *
              longint'(scaled_ratio(mg * 20, 65536, 1, 13, dur, 64'd1 << 31));
      end else begin
        w = dur - u;
        ph = PH_DECEL;
        pos = qe - (ng ? -1 : 1) *
              longint'(scaled_ratio(mg * 200, w, w, 91 * dur, dur, 64'd1 << 34));
        vel = (ng ? -1 : 1) *
              longint'(scaled_ratio(mg * 400, w, 65536, 91 * dur, dur, 64'd1 << 31));
        acc = ng ? longint'(acc_mag) : -longint'(acc_mag);
      end
    end
    r.position = clamp32(pos);
    r.velocity = clamp32(vel);
    r.acceleration = clamp32(acc);
    r.phase = ph;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %0d at %0t: %s got %h want %h", mismatches, $realtime, what, got, want);
  endtask

  // driver: one request per queued sample time, random gap after each
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.now <= 32'd0;
      send_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) profile_q.push_back(profile_at(in_bus.now));
      if (in_bus.valid && !in_bus.ready) begin
        // hold the request
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (pending_now.size() > 0) begin
        in_bus.valid <= 1'b1;
        in_bus.now <= pending_now.pop_front();
        send_gap <= no_idle ? 0 : $urandom_range(0, 15);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // monitor: compare each result with the oldest prediction, random stalls
  always @(posedge clk) begin
    sample_t want;
    int nxt;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      take_stall <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (profile_q.size() == 0) begin
          report("unexpected result", out_bus.position, 32'd0);
        end else begin
          want = profile_q.pop_front();
          if (out_bus.position !== want.position)
            report("position", out_bus.position, want.position);
          if (out_bus.velocity !== want.velocity)
            report("velocity", out_bus.velocity, want.velocity);
          if (out_bus.acceleration !== want.acceleration)
            report("acceleration", out_bus.acceleration, want.acceleration);
          if (out_bus.phase !== want.phase)
            report("phase", 32'(out_bus.phase), 32'(want.phase));
        end
        // draw the stall before the next result
        nxt = no_idle ? 0 : $urandom_range(0, 15);
        take_stall <= nxt;
        out_bus.ready <= (nxt == 0);
      end else if (take_stall > 0) begin
        take_stall <= take_stall - 1;
        out_bus.ready <= (take_stall == 1);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // wait until nothing is in flight, then let the pipeline drain
  // checked at the falling edge so the driver's updates have landed
  task automatic wait_quiet();
    while (pending_now.size() > 0 || in_bus.valid || profile_q.size() > 0) @(negedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START_POS:     cur_start = value;
      REG_END_POS:       cur_end = value;
      REG_MOVE_DURATION: cur_dur = value;
      default:           cur_t0 = value;
    endcase
  endtask

  // new move; only called with the block idle
  task automatic set_move(logic [31:0] s, logic [31:0] e, logic [31:0] d, logic [31:0] t0);
    wait_quiet();
    apb_write(REG_START_POS, s);
    apb_write(REG_END_POS, e);
    apb_write(REG_MOVE_DURATION, d);
    apb_write(REG_START_TIME, t0);
    // derived terms settle
    repeat (4) @(posedge clk);
  endtask

  // sample time mostly inside the move window, sometimes anywhere
  function automatic logic [31:0] pick_now();
    longint unsigned span;
    longint unsigned off;
    if ($urandom_range(0, 9) < 2) return $urandom();
    span = longint'(cur_dur) + longint'(cur_dur >> 1) + 3;
    off = {$urandom(), $urandom()} % span;
    return cur_t0 + 32'(off) - (cur_dur >> 2) - 32'd1;
  endfunction

  initial begin
    logic [31:0] s;
    logic [31:0] e;
    logic [31:0] d;
    logic [31:0] t0;
    int sel;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_bus.valid = 1'b0; in_bus.now = 32'd0; out_bus.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // tiny move out of reset
    pending_now.push_back(32'd0);
    pending_now.push_back(32'hffffffff);
    pending_now.push_back(32'h00008000);

    // full swing move: every phase and its edges, wrap of elapsed time
    set_move(32'h80000000, 32'h7fffffff, 32'd65536, 32'd100);
    pending_now.push_back(32'd99);          // before start
    pending_now.push_back(32'd100);         // zero elapsed
    pending_now.push_back(32'd100 + 22937); // end of accelerate
    pending_now.push_back(32'd100 + 22938);
    pending_now.push_back(32'd100 + 32768); // cruise
    pending_now.push_back(32'd100 + 42598);
    pending_now.push_back(32'd100 + 42599); // decelerate
    pending_now.push_back(32'd100 + 65536); // last decelerate sample
    pending_now.push_back(32'd100 + 65537); // done
    pending_now.push_back(32'h80000063);    // elapsed most positive
    pending_now.push_back(32'h80000064 - 1);

    // reverse direction, shortest and longest durations, zero duration
    set_move(32'h7fffffff, 32'h80000000, 32'd1, 32'hffffffff);
    pending_now.push_back(32'hffffffff);
    pending_now.push_back(32'd0);
    pending_now.push_back(32'hfffffffe);
    set_move(32'h01000000, 32'h00000000, 32'hffffffff, 32'd0);
    pending_now.push_back(32'h7fffffff);
    pending_now.push_back(32'h00000001);
    set_move(32'd0, 32'd1678, 32'd0, 32'd5);
    pending_now.push_back(32'd5);
    pending_now.push_back(32'd4);
    set_move(32'd0, 32'hfffff972, 32'd1000, 32'd0); // magnitude at the tiny limit
    pending_now.push_back(32'd500);

    // random moves
    for (int ph = 0; ph < 20; ph++) begin
      sel = $urandom_range(0, 9);
      s = $urandom();
      if (sel == 0) e = s + $urandom_range(0, 3355) - 32'd1677;
      else if (sel < 4) e = s + $urandom_range(0, 1 << 26) - 32'd33554432;
      else e = $urandom();
      if ($urandom_range(0, 4) == 0) d = $urandom() | 32'd1;
      else d = $urandom_range(1, 1 << 20);
      t0 = $urandom();
      set_move(s, e, d, t0);
      no_idle = (ph % 5 == 2);
      for (int k = 0; k < 96; k++) pending_now.push_back(pick_now());
    end

    wait_quiet();
    if (mismatches == 0 && profile_q.size() == 0) begin
      $display("** trapezoidal_profile_evaluator_top: PASSED **");
    end else begin
      $display("** trapezoidal_profile_evaluator_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("** trapezoidal_profile_evaluator_top: FAILED **");
    $finish;
  end

endmodule
